### rtl/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants of the byte-stuffing frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_WORD   = 2'd1,
        CMD_BYTE   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    localparam logic CFG_END_BYTE = 1'b0;
    localparam logic CFG_CAPACITY = 1'b1;

    localparam logic [7:0]  ID_OFFSET      = 8'h80;
    localparam logic [7:0]  ESC_BYTE       = 8'hDB;
    localparam logic [7:0]  ESC_END_BYTE   = 8'hDC;
    localparam logic [7:0]  ESC_ESC_BYTE   = 8'hDD;
    localparam logic [7:0]  END_BYTE_RESET = 8'd10;
    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    localparam int FIFO_DEPTH = 4;

    // One raw byte on its way to the stuffing stage, or a terminator request.
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic     empty;
        q_entry_t entry;
    } q_head_t;

endpackage

### rtl/bsfe_front.sv
// ----------------------------------------------------------------------------
// bsfe_front
// Accepts commands and breaks them into raw bytes, one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module bsfe_front
    import bsfe_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [111:0]   s_axis_tdata,  // message_id, timestamp, word_value, byte_value
    input  logic [1:0]     s_axis_tuser,  // command
    input  logic           q_full,
    output q_push_t        q_push
);

    logic [7:0]  message_id;
    logic [63:0] timestamp;
    logic [31:0] word_value;
    logic [7:0]  byte_value;
    cmd_t        command;

    logic        busy_reg, busy_next;
    cmd_t        cmd_reg, cmd_next;
    logic [71:0] shift_reg, shift_next;
    logic [3:0]  count_reg, count_next;
    logic        push;
    logic        accept;

    assign message_id = s_axis_tdata[7:0];
    assign timestamp  = s_axis_tdata[71:8];
    assign word_value = s_axis_tdata[103:72];
    assign byte_value = s_axis_tdata[111:104];
    assign command    = cmd_t'(s_axis_tuser);

    assign push          = busy_reg && !q_full;
    // The next word is taken in the same cycle as the last byte leaves.
    assign s_axis_tready = !busy_reg || (push && (count_reg == 4'd1));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        q_push.valid        = push;
        q_push.entry.is_end = (cmd_reg == CMD_END);
        q_push.entry.data   = shift_reg[7:0];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cmd_next   = cmd_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cmd_next  = command;
            unique case (command)
                CMD_HEADER:
                begin
                    shift_next = {timestamp, message_id + ID_OFFSET};
                    count_next = 4'd9;
                end
                CMD_WORD:
                begin
                    shift_next = {40'd0, word_value};
                    count_next = 4'd4;
                end
                CMD_BYTE:
                begin
                    shift_next = {64'd0, byte_value};
                    count_next = 4'd1;
                end
                default:
                begin
                    shift_next = 72'd0;
                    count_next = 4'd1;
                end
            endcase
        end
        else if (push)
        begin
            shift_next = {8'd0, shift_reg[71:8]};
            count_next = count_reg - 4'd1;
            busy_next  = (count_reg != 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 4'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        shift_reg <= shift_next;
    end

endmodule

### rtl/bsfe_fifo.sv
// ----------------------------------------------------------------------------
// bsfe_fifo
// Short first-in first-out queue of raw bytes between front and back.
// ----------------------------------------------------------------------------
module bsfe_fifo
    import bsfe_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_push,
    output logic    q_full,
    input  logic    q_pop,
    output q_head_t q_head
);

    localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
    localparam int CntW = $clog2(FifoDepth + 1);

    q_entry_t            mem_reg [FifoDepth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign q_full       = (cnt_reg == CntW'(FifoDepth));
    assign q_head.empty = (cnt_reg == '0);
    assign q_head.entry = mem_reg[rd_ptr_reg];
    assign do_push      = q_push.valid && !q_full;
    assign do_pop       = q_pop && !q_head.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

### rtl/bsfe_back.sv
// ----------------------------------------------------------------------------
// bsfe_back
// Stuffs raw bytes, tracks the frame slot and drives the output register.
// ----------------------------------------------------------------------------
module bsfe_back
    import bsfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  end_byte,
    input  logic [15:0] capacity,
    input  q_head_t     q_head,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_byte, position
    output logic [0:0]  m_axis_tuser,  // replace_last
    output logic        m_axis_tlast   // frame_end
);

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] pos_reg, pos_next;
    logic        repl_reg, repl_next;
    logic        last_reg, last_next;
    logic [15:0] wp_reg, wp_next;
    logic        pend_reg, pend_next;
    logic [7:0]  second_reg, second_next;

    logic        out_free;
    logic        room_one;
    logic        room_pair;
    logic        is_special;
    logic [7:0]  hd;

    assign out_free   = !valid_reg || m_axis_tready;
    assign hd         = q_head.entry.data;
    assign room_one   = (wp_reg < capacity);
    assign room_pair  = (({1'b0, wp_reg} + 17'd1) < {1'b0, capacity});
    assign is_special = (hd == end_byte) || (hd == ESC_BYTE);

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {pos_reg, byte_reg};
    assign m_axis_tuser  = repl_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        valid_next  = valid_reg && !m_axis_tready;
        byte_next   = byte_reg;
        pos_next    = pos_reg;
        repl_next   = repl_reg;
        last_next   = last_reg;
        wp_next     = wp_reg;
        pend_next   = pend_reg;
        second_next = second_reg;
        q_pop       = 1'b0;

        if (out_free && pend_reg)
        begin
            // Second half of an escape pair.
            valid_next = 1'b1;
            byte_next  = second_reg;
            pos_next   = wp_reg;
            repl_next  = 1'b0;
            last_next  = 1'b0;
            wp_next    = wp_reg + 16'd1;
            pend_next  = 1'b0;
        end
        else if (out_free && !q_head.empty)
        begin
            q_pop = 1'b1;
            if (q_head.entry.is_end)
            begin
                wp_next   = 16'd0;
                byte_next = end_byte;
                last_next = 1'b1;
                if (room_one)
                begin
                    valid_next = 1'b1;
                    pos_next   = wp_reg;
                    repl_next  = 1'b0;
                end
                else if (capacity != 16'd0)
                begin
                    // Full frame: the terminator overwrites the final slot.
                    valid_next = 1'b1;
                    pos_next   = capacity - 16'd1;
                    repl_next  = 1'b1;
                end
            end
            else if (is_special)
            begin
                if (room_pair)
                begin
                    valid_next  = 1'b1;
                    byte_next   = ESC_BYTE;
                    pos_next    = wp_reg;
                    repl_next   = 1'b0;
                    last_next   = 1'b0;
                    wp_next     = wp_reg + 16'd1;
                    pend_next   = 1'b1;
                    // The end-byte test wins when the end byte is the escape byte.
                    second_next = (hd == end_byte) ? ESC_END_BYTE : ESC_ESC_BYTE;
                end
            end
            else if (room_one)
            begin
                valid_next = 1'b1;
                byte_next  = hd;
                pos_next   = wp_reg;
                repl_next  = 1'b0;
                last_next  = 1'b0;
                wp_next    = wp_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wp_reg    <= 16'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            wp_reg    <= wp_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        pos_reg    <= pos_next;
        repl_reg   <= repl_next;
        last_reg   <= last_next;
        second_reg <= second_next;
    end

endmodule

### rtl/byte_stuffing_frame_encoder.sv
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder
// Builds byte-stuffed frames with a capacity limit from header, word, byte
// and end commands.
//
// Channel  Direction  Payload
// s_axis   in         tuser: command; tdata: message_id, timestamp,
//                     word_value, byte_value
// m_axis   out        tdata: out_byte, position; tuser: replace_last;
//                     tlast: frame_end
// cfg      in         cfg_index 0 end_byte, 1 capacity
//
// The front unpacks a command into raw bytes at one per cycle while the queue
// has room, and takes the next command as the last byte of the current one
// leaves. The back emits one output word per cycle while the receiver is
// ready; an escape pair gives two words and a dropped byte none. Reset clears
// the queue, the slot counter and the output valid flag.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder
    import bsfe_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // message_id, timestamp, word_value, byte_value
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // out_byte, position
    output logic [0:0]   m_axis_tuser,  // replace_last
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [7:0]  end_byte_reg;
    logic [15:0] capacity_reg;
    q_push_t     q_push;
    q_head_t     q_head;
    logic        q_full;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_byte_reg <= END_BYTE_RESET;
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_END_BYTE: end_byte_reg <= cfg_data[7:0];
                CFG_CAPACITY: capacity_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    bsfe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push)
    );

    bsfe_fifo #(
        .FifoDepth (FifoDepth)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    bsfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .end_byte      (end_byte_reg),
        .capacity      (capacity_reg),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### tb/byte_stuffing_frame_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder_tb
// Drives header, word, byte and end commands into the encoder and checks every
// encoded output word against a behavioral predictor of the stuffing and
// capacity rules. The run covers directed corner cases, seeded random frames
// under several idle and stall mixes, and a long output hold-off.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder_tb;
    import bsfe_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [7:0]  data;
        logic [15:0] slot;
        logic        repl;
        logic        last;
    } enc_byte_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;  // message_id, timestamp, word_value, byte_value
    logic [1:0]   s_axis_tuser = '0;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;       // out_byte, position
    logic [0:0]   m_axis_tuser;       // replace_last
    logic         m_axis_tlast;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;

    // Encoder image kept by the testbench.
    logic [7:0]  term_byte;
    int unsigned frame_cap;
    int unsigned frame_pos;

    enc_byte_t expected_bytes[$];
    int        mismatches = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    byte_stuffing_frame_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b, input int unsigned pos,
                                      input logic repl, input logic last);
        enc_byte_t e;
        e.data = b;
        e.slot = pos[15:0];
        e.repl = repl;
        e.last = last;
        expected_bytes.push_back(e);
    endfunction

    function automatic void stuff_byte(input logic [7:0] b);
        if (b == term_byte || b == ESC_BYTE) begin
            // An escape pair goes out whole or not at all.
            if (frame_pos + 1 >= frame_cap)
                return;
            push_byte(ESC_BYTE, frame_pos, 1'b0, 1'b0);
            frame_pos++;
            push_byte((b == term_byte) ? ESC_END_BYTE : ESC_ESC_BYTE, frame_pos, 1'b0, 1'b0);
            frame_pos++;
        end
        else begin
            if (frame_pos >= frame_cap)
                return;
            push_byte(b, frame_pos, 1'b0, 1'b0);
            frame_pos++;
        end
        frame_pos &= 32'hFFFF;
    endfunction

    function automatic void predict_command(input cmd_t cmd, input logic [7:0] id,
                                            input logic [63:0] ts, input logic [31:0] wv,
                                            input logic [7:0] bv);
        case (cmd)
            CMD_HEADER:
            begin
                stuff_byte(ID_OFFSET + id);
                for (int i = 0; i < 8; i++)
                    stuff_byte(ts[8*i +: 8]);
            end
            CMD_WORD:
            begin
                for (int i = 0; i < 4; i++)
                    stuff_byte(wv[8*i +: 8]);
            end
            CMD_BYTE:
                stuff_byte(bv);
            default:
            begin
                // A full frame has its final slot overwritten by the terminator.
                if (frame_pos >= frame_cap) begin
                    if (frame_cap > 0)
                        push_byte(term_byte, frame_cap - 1, 1'b1, 1'b1);
                end
                else
                    push_byte(term_byte, frame_pos, 1'b0, 1'b1);
                frame_pos = 0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Shared driver tasks; each starts and ends just after a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input cmd_t cmd, input logic [7:0] id, input logic [63:0] ts,
                             input logic [31:0] wv, input logic [7:0] bv);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {bv, wv, ts, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_command(cmd, id, ts, wv, bv);
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected word has arrived, then lets
    // the block finish any bytes it drops without output.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] end_val, input logic [15:0] cap_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_END_BYTE;
        cfg_data  <= {8'h00, end_val};
        @(negedge clk);
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= cap_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        term_byte = end_val;
        frame_cap = 32'(cap_val);
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_payload_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return term_byte;
        else if (r < 40)
            return ESC_BYTE;
        else
            return 8'($urandom_range(255));
    endfunction

    function automatic logic [31:0] rand_stream_word();
        return {rand_payload_byte(), rand_payload_byte(), rand_payload_byte(),
                rand_payload_byte()};
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_item(CMD_HEADER, 8'h7F, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
        send_item(CMD_HEADER, 8'h80, 64'h0000_DB0A_0A00_DB01, '0, '0);
        send_item(CMD_WORD, '0, '0, 32'hDB0A_00FF, '0);
        send_item(CMD_BYTE, '0, '0, '0, 8'h0A);
        send_item(CMD_BYTE, '0, '0, '0, 8'hDB);
        send_item(CMD_BYTE, '0, '0, '0, 8'hFF);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_capacity_limits();
        configure(8'h0A, 16'd4);
        send_item(CMD_BYTE, '0, '0, '0, 8'h01);
        send_item(CMD_BYTE, '0, '0, '0, 8'h02);
        send_item(CMD_BYTE, '0, '0, '0, 8'h03);
        // Only one slot is left, so the escape pair is dropped.
        send_item(CMD_BYTE, '0, '0, '0, 8'h0A);
        send_item(CMD_BYTE, '0, '0, '0, 8'h04);
        send_item(CMD_BYTE, '0, '0, '0, 8'h05);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
        configure(8'h0A, 16'd0);
        send_item(CMD_BYTE, '0, '0, '0, 8'h07);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
        configure(8'h0A, 16'd1);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_end_byte_values();
        // With the end byte equal to the escape byte, the end-byte rule wins.
        configure(ESC_BYTE, 16'd64);
        send_item(CMD_BYTE, '0, '0, '0, ESC_BYTE);
        send_item(CMD_BYTE, '0, '0, '0, 8'h0A);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
        configure(8'h00, 16'hFFFF);
        send_item(CMD_HEADER, 8'h80, 64'h0123_4567_89AB_CDEF, '0, '0);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
        configure(8'hFF, 16'd300);
        send_item(CMD_HEADER, 8'h7F, 64'h0000_0000_0000_0000, '0, '0);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_capacity_lowered();
        configure(8'h0A, 16'd256);
        send_item(CMD_WORD, '0, '0, 32'h1122_3344, '0);
        wait_idle();
        configure(8'h0A, 16'd2);
        send_item(CMD_BYTE, '0, '0, '0, 8'h55);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        configure(8'h0A, 16'd1000);
        hold_left = HOLD_CYCLES;
        repeat (20)
            send_item(CMD_WORD, '0, '0, rand_stream_word(), '0);
        send_item(CMD_END, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_frames(input int n_items, input int idle_pct,
                                      input int stall_pct);
        int   sent;
        int   len;
        int   r;
        logic [7:0]  end_val;
        logic [15:0] cap_val;
        cmd_t cmd;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 35) begin
                wait_idle();
                r = $urandom_range(99);
                if (r < 40)
                    end_val = END_BYTE_RESET;
                else if (r < 55)
                    end_val = ESC_BYTE;
                else if (r < 65)
                    end_val = 8'h00;
                else if (r < 75)
                    end_val = 8'hFF;
                else
                    end_val = 8'($urandom_range(255));
                r = $urandom_range(99);
                if (r < 60)
                    cap_val = 16'($urandom_range(24));
                else if (r < 85)
                    cap_val = 16'($urandom_range(300, 25));
                else
                    cap_val = 16'($urandom_range(65535));
                configure(end_val, cap_val);
            end
            len = $urandom_range(8, 1);
            repeat (len) begin
                // A stray end now and then breaks up the frame.
                if ($urandom_range(99) < 8)
                    cmd = CMD_END;
                else
                    cmd = cmd_t'($urandom_range(2));
                send_item(cmd, 8'($urandom_range(255)),
                          {rand_stream_word(), rand_stream_word()},
                          rand_stream_word(), rand_payload_byte());
                sent++;
            end
            if ($urandom_range(99) < 88) begin
                send_item(CMD_END, '0, '0, '0, '0);
                sent++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk) begin
        enc_byte_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: byte %h slot %0d repl %b last %b", $time,
                         m_axis_tdata[7:0], m_axis_tdata[23:8], m_axis_tuser[0],
                         m_axis_tlast);
            end
            else begin
                e = expected_bytes.pop_front();
                if (m_axis_tdata[7:0] !== e.data) begin
                    mismatches++;
                    $display("%0t: out_byte expected %h actual %h", $time, e.data,
                             m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[23:8] !== e.slot) begin
                    mismatches++;
                    $display("%0t: position expected %0d actual %0d", $time, e.slot,
                             m_axis_tdata[23:8]);
                end
                if (m_axis_tuser[0] !== e.repl) begin
                    mismatches++;
                    $display("%0t: replace_last expected %b actual %b", $time, e.repl,
                             m_axis_tuser[0]);
                end
                if (m_axis_tlast !== e.last) begin
                    mismatches++;
                    $display("%0t: frame_end expected %b actual %b", $time, e.last,
                             m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        term_byte = END_BYTE_RESET;
        frame_cap = 32'(CAPACITY_RESET);
        frame_pos = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_capacity_limits();
        test_end_byte_values();
        test_capacity_lowered();
        test_backpressure();
        test_random_frames(25, 0, 0);
        test_random_frames(25, 69, 0);
        test_random_frames(25, 0, 69);
        test_random_frames(25, 20, 20);

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
